// ----- hdl/coordinate_keyed_countdown_timers_defines.svh -----
`ifndef COORDINATE_KEYED_COUNTDOWN_TIMERS_DEFINES_SVH
`define COORDINATE_KEYED_COUNTDOWN_TIMERS_DEFINES_SVH

// checked at every clock edge, masked while reset is held
`define CKCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every clock edge, reset included
`define CKCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/ckct_pkg.sv -----
`default_nettype none

package ckct_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_COORD_BITS  = 8;

    localparam int KEY_W  = 8;
    localparam int LIFE_W = 16;

    localparam logic [LIFE_W-1:0] START_LIFE_RST = 16'd3000;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } chain_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/ckct_cell.sv -----
`default_nettype none

module ckct_cell #(
    parameter int COORD_BITS = ckct_pkg::DEF_COORD_BITS
) (
    input  wire logic                          aclk,
    input  wire ckct_pkg::chain_ctl_t          ctl,
    input  wire logic [COORD_BITS-1:0]         load_x,
    input  wire logic [COORD_BITS-1:0]         load_y,
    input  wire logic [ckct_pkg::LIFE_W-1:0]   load_life,
    input  wire logic [COORD_BITS-1:0]         nb_x,
    input  wire logic [COORD_BITS-1:0]         nb_y,
    input  wire logic [ckct_pkg::LIFE_W-1:0]   nb_life,
    output logic      [COORD_BITS-1:0]         x,
    output logic      [COORD_BITS-1:0]         y,
    output logic      [ckct_pkg::LIFE_W-1:0]   life
);

    logic [COORD_BITS-1:0]       x_reg, x_next;
    logic [COORD_BITS-1:0]       y_reg, y_next;
    logic [ckct_pkg::LIFE_W-1:0] life_reg, life_next;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        life_next = life_reg;
        if (ctl.load) begin
            x_next    = load_x;
            y_next    = load_y;
            life_next = load_life;
        end else if (ctl.shift) begin
            x_next    = nb_x;
            y_next    = nb_y;
            life_next = nb_life;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        life_reg <= life_next;
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign life = life_reg;

endmodule

`default_nettype wire

// ----- hdl/ckct_ctrl.sv -----
`default_nettype none

`include "coordinate_keyed_countdown_timers_defines.svh"

module ckct_ctrl #(
    parameter int TABLE_DEPTH = ckct_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = ckct_pkg::DEF_COORD_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_kind,
    input  wire logic [ckct_pkg::KEY_W-1:0]           s_coord_x,
    input  wire logic [ckct_pkg::KEY_W-1:0]           s_coord_y,
    input  wire logic [ckct_pkg::LIFE_W-1:0]          s_interval,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_status,
    output logic      [ckct_pkg::LIFE_W-1:0]          m_remaining,
    output logic                                      m_expired,
    output logic      [ckct_pkg::KEY_W-1:0]           m_expired_x,
    output logic      [ckct_pkg::KEY_W-1:0]           m_expired_y,
    output logic                                      m_last,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ckct_pkg::LIFE_W-1:0]          cfg_wr_data,
    input  wire logic [COORD_BITS-1:0]                head_x,
    input  wire logic [COORD_BITS-1:0]                head_y,
    input  wire logic [ckct_pkg::LIFE_W-1:0]          head_life,
    output logic      [COORD_BITS-1:0]                tail_x,
    output logic      [COORD_BITS-1:0]                tail_y,
    output logic      [ckct_pkg::LIFE_W-1:0]          tail_life,
    output logic      [COORD_BITS-1:0]                load_x,
    output logic      [COORD_BITS-1:0]                load_y,
    output logic      [ckct_pkg::LIFE_W-1:0]          load_life,
    output ckct_pkg::chain_ctl_t [TABLE_DEPTH-1:0]    cell_ctl
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW    = ckct_pkg::LIFE_W;
    localparam int KW    = ckct_pkg::KEY_W;

    ckct_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [LW-1:0]    start_life_reg, start_life_next;
    logic [LW-1:0]    found_reg, found_next;
    logic             query_reg, query_next;
    logic [COORD_BITS-1:0] key_x_reg, key_x_next;
    logic [COORD_BITS-1:0] key_y_reg, key_y_next;
    logic [LW-1:0]    interval_reg, interval_next;

    logic             out_vld_reg, out_vld_next;
    logic             out_status_reg, out_status_next;
    logic [LW-1:0]    out_remaining_reg, out_remaining_next;
    logic             out_expired_reg, out_expired_next;
    logic [KW-1:0]    out_ex_reg, out_ex_next;
    logic [KW-1:0]    out_ey_reg, out_ey_next;
    logic             out_last_reg, out_last_next;

    logic             step_ok;
    logic             accept;
    logic             emit;
    logic             shift;
    logic             add_go;
    logic             head_live;
    logic [LW-1:0]    life_sub;
    logic [LW-1:0]    life_new;

    assign step_ok   = !out_vld_reg || m_ready;
    assign s_ready   = (state_reg == ckct_pkg::ST_IDLE) && step_ok;
    assign accept    = s_valid && s_ready;
    assign head_live = CNT_W'(step_reg) < count_reg;
    assign life_sub  = (head_life > interval_reg) ? head_life - interval_reg : '0;

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        step_next          = step_reg;
        found_next         = found_reg;
        query_next         = query_reg;
        key_x_next         = key_x_reg;
        key_y_next         = key_y_reg;
        interval_next      = interval_reg;
        start_life_next    = cfg_wr_en ? cfg_wr_data : start_life_reg;
        life_new           = head_life;
        emit               = 1'b0;
        shift              = 1'b0;
        add_go             = 1'b0;
        out_status_next    = 1'b0;
        out_remaining_next = '0;
        out_expired_next   = 1'b0;
        out_ex_next        = '0;
        out_ey_next        = '0;
        out_last_next      = 1'b0;

        case (state_reg)
            ckct_pkg::ST_IDLE: begin
                if (accept) begin
                    case (ckct_pkg::kind_t'(s_kind))
                        ckct_pkg::KIND_ADD: begin
                            emit          = 1'b1;
                            out_last_next = 1'b1;
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                out_status_next = 1'b1;
                            end else begin
                                add_go     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ckct_pkg::KIND_QUERY, ckct_pkg::KIND_TICK: begin
                            query_next    = (ckct_pkg::kind_t'(s_kind) == ckct_pkg::KIND_QUERY);
                            key_x_next    = COORD_BITS'(s_coord_x);
                            key_y_next    = COORD_BITS'(s_coord_y);
                            interval_next = s_interval;
                            found_next    = '0;
                            step_next     = '0;
                            state_next    = ckct_pkg::ST_SCAN;
                        end
                        ckct_pkg::KIND_CLEAR: begin
                            emit          = 1'b1;
                            out_last_next = 1'b1;
                            count_next    = '0;
                        end
                        default: begin
                            emit          = 1'b1;
                            out_last_next = 1'b1;
                        end
                    endcase
                end
            end
            ckct_pkg::ST_SCAN: begin
                if (step_ok) begin
                    shift     = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (query_reg) begin
                        if (head_live && head_x == key_x_reg && head_y == key_y_reg) begin
                            found_next = head_life;
                        end
                    end else if (head_live && head_life != '0) begin
                        life_new = life_sub;
                        if (life_sub == '0) begin
                            emit             = 1'b1;
                            out_expired_next = 1'b1;
                            out_ex_next      = KW'(head_x);
                            out_ey_next      = KW'(head_y);
                        end
                    end
                    if (step_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                        state_next = ckct_pkg::ST_DONE;
                    end
                end
            end
            ckct_pkg::ST_DONE: begin
                if (step_ok) begin
                    emit               = 1'b1;
                    out_last_next      = 1'b1;
                    out_remaining_next = query_reg ? found_reg : '0;
                    state_next         = ckct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ckct_pkg::ST_IDLE;
            end
        endcase

        out_vld_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_ctl[i].shift = shift;
            cell_ctl[i].load  = add_go && (count_reg == CNT_W'(i));
        end
    end

    assign tail_x    = head_x;
    assign tail_y    = head_y;
    assign tail_life = life_new;
    assign load_x    = COORD_BITS'(s_coord_x);
    assign load_y    = COORD_BITS'(s_coord_y);
    assign load_life = start_life_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ckct_pkg::ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            start_life_reg <= ckct_pkg::START_LIFE_RST;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            start_life_reg <= start_life_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg    <= found_next;
        query_reg    <= query_next;
        key_x_reg    <= key_x_next;
        key_y_reg    <= key_y_next;
        interval_reg <= interval_next;
        if (emit) begin
            out_status_reg    <= out_status_next;
            out_remaining_reg <= out_remaining_next;
            out_expired_reg   <= out_expired_next;
            out_ex_reg        <= out_ex_next;
            out_ey_reg        <= out_ey_next;
            out_last_reg      <= out_last_next;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_status    = out_status_reg;
    assign m_remaining = out_remaining_reg;
    assign m_expired   = out_expired_reg;
    assign m_expired_x = out_ex_reg;
    assign m_expired_y = out_ey_reg;
    assign m_last      = out_last_reg;

    `CKCT_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "entry count past table depth")
    `CKCT_ASSERT(a_clear_empties, accept && s_kind == ckct_pkg::KIND_CLEAR |=> count_reg == '0, "clear left entries")
    `CKCT_ASSERT(a_full_add_holds, accept && s_kind == ckct_pkg::KIND_ADD && count_reg == CNT_W'(TABLE_DEPTH) |=> $stable(count_reg), "rejected add changed count")
    `CKCT_ASSERT(a_expiry_not_last, out_vld_reg && out_expired_reg |-> !out_last_reg, "expiry request marked last")
    `CKCT_ASSERT(a_scan_end, state_reg == ckct_pkg::ST_SCAN && step_ok && step_reg == IDX_W'(TABLE_DEPTH - 1) |=> state_reg == ckct_pkg::ST_DONE, "scan did not finish")

endmodule

`default_nettype wire

// ----- hdl/coordinate_keyed_countdown_timers.sv -----
// add and clear: one request out in the cycle after accept, next item accepted once it is taken
// query and tick: table rotates one cell per cycle through the head while the result side
// does not stall, through all TABLE_DEPTH cells, then a final request marked last
// reset (aresetn low, synchronous): table empty, start lifetime 3000, no request pending
// timer cells hold no reset; only entries below the count are ever read
`default_nettype none

module coordinate_keyed_countdown_timers #(
    parameter int TABLE_DEPTH = ckct_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = ckct_pkg::DEF_COORD_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic [ckct_pkg::KEY_W-1:0]       s_coord_x,
    input  wire logic [ckct_pkg::KEY_W-1:0]       s_coord_y,
    input  wire logic [ckct_pkg::LIFE_W-1:0]      s_interval,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_status,
    output logic      [ckct_pkg::LIFE_W-1:0]      m_remaining,
    output logic                                  m_expired,
    output logic      [ckct_pkg::KEY_W-1:0]       m_expired_x,
    output logic      [ckct_pkg::KEY_W-1:0]       m_expired_y,
    output logic                                  m_last,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ckct_pkg::LIFE_W-1:0]      cfg_wr_data
);

    localparam int LW = ckct_pkg::LIFE_W;

    logic [COORD_BITS-1:0] cell_x    [TABLE_DEPTH];
    logic [COORD_BITS-1:0] cell_y    [TABLE_DEPTH];
    logic [LW-1:0]         cell_life [TABLE_DEPTH];

    logic [COORD_BITS-1:0] tail_x, tail_y, load_x, load_y;
    logic [LW-1:0]         tail_life, load_life;

    ckct_pkg::chain_ctl_t [TABLE_DEPTH-1:0] cell_ctl;

    ckct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_interval  (s_interval),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_remaining (m_remaining),
        .m_expired   (m_expired),
        .m_expired_x (m_expired_x),
        .m_expired_y (m_expired_y),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_x      (cell_x[0]),
        .head_y      (cell_y[0]),
        .head_life   (cell_life[0]),
        .tail_x      (tail_x),
        .tail_y      (tail_y),
        .tail_life   (tail_life),
        .load_x      (load_x),
        .load_y      (load_y),
        .load_life   (load_life),
        .cell_ctl    (cell_ctl)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [COORD_BITS-1:0] nb_x, nb_y;
        logic [LW-1:0]         nb_life;

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign nb_x    = tail_x;
            assign nb_y    = tail_y;
            assign nb_life = tail_life;
        end else begin : g_link
            assign nb_x    = cell_x[i+1];
            assign nb_y    = cell_y[i+1];
            assign nb_life = cell_life[i+1];
        end

        ckct_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[i]),
            .load_x    (load_x),
            .load_y    (load_y),
            .load_life (load_life),
            .nb_x      (nb_x),
            .nb_y      (nb_y),
            .nb_life   (nb_life),
            .x         (cell_x[i]),
            .y         (cell_y[i]),
            .life      (cell_life[i])
        );
    end

endmodule

`default_nettype wire
